FILE: rtl/core/lavm_pkg.sv
// Shared constants, register codes and fixed-point helpers of the look-at view matrix unit.
package lavm_pkg;

  localparam int SQRT_LAT   = 32;  // one root bit per stage
  localparam int DVD_W      = 48;  // dividend width of the divider
  localparam int DVS_W      = 32;  // divisor width of the divider
  localparam int DIV_LAT    = 48;  // one quotient bit per stage
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int NUM_ROWS   = 4;
  localparam int ROW_W      = 2;

  // front end 5, two roots, two divisions, unit vectors 1, dot/clamp 4,
  // reciprocal 1, matrix rows 8
  localparam int PIPE_LAT = 5 + 2 * SQRT_LAT + 2 * DIV_LAT + 1 + 4 + 1 + 8;

  localparam logic [30:0]        MAX31     = 31'h7FFF_FFFF;
  localparam logic [30:0]        RATIO_RST = 31'd6553600;
  localparam logic signed [19:0] VZ_ONE    = 20'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR  = 2'd0,
    CFG_FAR   = 2'd1,
    CFG_RATIO = 2'd2,
    CFG_LINE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [ROW_W-1:0] {
    ROW_X     = 2'd0,
    ROW_Y     = 2'd1,
    ROW_Z     = 2'd2,
    ROW_TRANS = 2'd3
  } row_e;

  // Q16.16 reduction: round half up
  function automatic logic signed [67:0] rnd16(input logic signed [67:0] x);
    return (x + 68'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > 68'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_rnd(input logic signed [67:0] x);
    return sat32(rnd16(x));
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
    logic signed [31:0] r;
    if (x == 32'sh8000_0000) begin
      r = 32'sh7FFF_FFFF;
    end else begin
      r = -x;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/lavm_cam_if.sv
// Camera input channel: eye, target and up vectors in Q16.16.
interface lavm_cam_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                up_x, up_y, up_z, output ready);
endinterface

FILE: rtl/core/lavm_row_if.sv
// Matrix row output channel: one row word with clip planes and flags.
interface lavm_row_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] col_zero;
  logic signed [31:0] col_one;
  logic signed [31:0] col_two;
  logic [30:0]        near_out;
  logic [30:0]        far_out;
  logic               degenerate;
  logic               last_row;

  modport source (output valid, row_index, col_zero, col_one, col_two, near_out, far_out,
                  degenerate, last_row, input ready);
  modport sink (input valid, row_index, col_zero, col_one, col_two, near_out, far_out,
                degenerate, last_row, output ready);
endinterface

FILE: rtl/core/lavm_sqrt.sv
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
module lavm_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import lavm_pkg::*;

  logic [63:0] rem_q  [SQRT_LAT];
  logic [31:0] root_q [SQRT_LAT];

  for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
    localparam int K = SQRT_LAT - 1 - s;
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] trial;

    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // (root + 2^K)^2 - root^2
    assign trial = ({32'b0, root_in} << (K + 1)) + (64'd1 << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[s]  <= rem_in - trial;
          root_q[s] <= root_in | (32'd1 << K);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[SQRT_LAT-1];

endmodule

FILE: rtl/core/lavm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module lavm_div (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [lavm_pkg::DVD_W-1:0] dvd_i,
  input  logic [lavm_pkg::DVS_W-1:0] dvs_i,
  output logic [lavm_pkg::DVD_W-1:0] quot_o
);
  import lavm_pkg::*;

  localparam int WIDE_W = DVD_W + DVS_W;

  logic [DVD_W-1:0] rem_q  [DIV_LAT];
  logic [DVD_W-1:0] quot_q [DIV_LAT];
  logic [DVS_W-1:0] dvs_q  [DIV_LAT];

  for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
    localparam int K = DIV_LAT - 1 - s;
    logic [DVD_W-1:0]  rem_in;
    logic [DVD_W-1:0]  quot_in;
    logic [DVS_W-1:0]  dvs_in;
    logic [WIDE_W-1:0] shifted;

    if (s == 0) begin : g_first
      assign rem_in  = dvd_i;
      assign quot_in = '0;
      assign dvs_in  = dvs_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign dvs_in  = dvs_q[s-1];
    end

    assign shifted = {{DVD_W{1'b0}}, dvs_in} << K;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvs_q[s] <= dvs_in;
        if ({{DVS_W{1'b0}}, rem_in} >= shifted) begin
          rem_q[s]  <= rem_in - shifted[DVD_W-1:0];
          quot_q[s] <= quot_in | (DVD_W'(1) << K);
        end else begin
          rem_q[s]  <= rem_in;
          quot_q[s] <= quot_in;
        end
      end
    end
  end

  assign quot_o = quot_q[DIV_LAT-1];

endmodule

FILE: rtl/core/look_at_view_matrix_unit.sv
// Look-at view matrix unit: camera word in, four matrix row words out.
// The first row word is valid once its camera word has crossed the pipeline;
//   the four rows follow on consecutive cycles when the sink is ready.
// The row serializer sets throughput; it frees as a matrix's last row leaves.
// The 179-stage pipeline takes one camera per cycle while its output can drain.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
module look_at_view_matrix_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lavm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lavm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lavm_cam_if.sink                        cam_i,
  lavm_row_if.source                      row_o
);
  import lavm_pkg::*;

  // Payload bundles riding alongside the arithmetic units
  typedef struct {
    logic signed [31:0] eye  [3];
    logic               neg  [2][3];
    logic               zero [2];
    logic signed [6:0]  e    [2];
    logic [32:0]        mag  [2][3];  // magnitude, later the scaled magnitude
  } front_t;

  typedef struct {
    logic signed [31:0] eye  [3];
    logic               neg  [2][3];
    logic               zero [2];
    logic signed [6:0]  e_d;
    logic [62:0]        far_prod;
  } back_t;

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [17:0] t   [3];
    logic signed [17:0] u   [3];
    logic [30:0]        near;
    logic [30:0]        far;
    logic signed [19:0] vz;
    logic               degen;
  } mid_t;

  typedef struct {
    mid_t               c;
    logic [30:0]        vyinv;
    logic signed [31:0] col0 [3];
    logic signed [31:0] col1 [3];
  } tail_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [30:0] near_q, far_q, ratio_q;
  logic        line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q  <= '0;
      far_q   <= '0;
      ratio_q <= RATIO_RST;
      line_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NEAR:  near_q  <= cfg_data_i;
        CFG_FAR:   far_q   <= cfg_data_i;
        CFG_RATIO: ratio_q <= cfg_data_i;
        CFG_LINE:  line_q  <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole pipe advances together; valid bits travel along.
  // ---------------------------------------------------------------------------
  logic                adv;
  logic                ser_free;
  logic                ser_vld_q;
  logic [ROW_W-1:0]    ser_row_q;
  logic [PIPE_LAT-1:0] vld_q;

  // Serializer can take a new matrix when empty or when its last row leaves now
  assign ser_free    = !ser_vld_q || (row_e'(ser_row_q) == ROW_TRANS && row_o.ready);
  assign adv         = !vld_q[PIPE_LAT-1] || ser_free;
  assign cam_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], cam_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // P0: capture the word, form the sight line
  // ---------------------------------------------------------------------------
  logic signed [31:0] eye0_q [3];
  logic signed [32:0] vec0_q [2][3];
  logic signed [31:0] in_eye [3];
  logic signed [31:0] in_tgt [3];
  logic signed [31:0] in_up  [3];

  assign in_eye = '{cam_i.eye_x, cam_i.eye_y, cam_i.eye_z};
  assign in_tgt = '{cam_i.target_x, cam_i.target_y, cam_i.target_z};
  assign in_up  = '{cam_i.up_x, cam_i.up_y, cam_i.up_z};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        eye0_q[i]    <= in_eye[i];
        vec0_q[0][i] <= 33'(in_tgt[i]) - 33'(in_eye[i]);
        vec0_q[1][i] <= 33'(in_up[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // P1: magnitudes, signs and the scale that puts the largest into [2^30, 2^31)
  // ---------------------------------------------------------------------------
  front_t f1_d, f1_q, f2_d, f2_q, f3_q, f4_q;

  always_comb begin
    logic [32:0] mx;
    logic [5:0]  pos;
    f1_d.eye = eye0_q;
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        f1_d.neg[v][i] = vec0_q[v][i][32];
        f1_d.mag[v][i] = vec0_q[v][i][32] ? 33'(-vec0_q[v][i]) : 33'(vec0_q[v][i]);
      end
      mx = f1_d.mag[v][0];
      if (f1_d.mag[v][1] > mx) mx = f1_d.mag[v][1];
      if (f1_d.mag[v][2] > mx) mx = f1_d.mag[v][2];
      pos = '0;
      for (int b = 0; b < 33; b++) begin
        if (mx[b]) pos = 6'(b);
      end
      f1_d.zero[v] = (mx == '0);
      f1_d.e[v]    = f1_d.zero[v] ? 7'sd0 : 7'sd30 - $signed({1'b0, pos});
    end
  end

  // P2: apply the scale
  always_comb begin
    logic [63:0] wide;
    logic [63:0] shifted;
    logic [6:0]  amt;
    f2_d = f1_q;
    for (int v = 0; v < 2; v++) begin
      amt = f1_q.e[v][6] ? 7'(-f1_q.e[v]) : 7'(f1_q.e[v]);
      for (int i = 0; i < 3; i++) begin
        wide    = 64'(f1_q.mag[v][i]);
        shifted = f1_q.e[v][6] ? (wide >> amt) : (wide << amt);
        f2_d.mag[v][i] = {2'b00, shifted[30:0]};
      end
    end
  end

  // P3 squares, P4 sum of squares
  logic [61:0] sqr_q [2][3];
  logic [63:0] ssq_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
      f3_q <= f2_q;
      f4_q <= f3_q;
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          sqr_q[v][i] <= 62'(f2_q.mag[v][i][30:0]) * 62'(f2_q.mag[v][i][30:0]);
        end
        ssq_q[v] <= 64'(sqr_q[v][0]) + 64'(sqr_q[v][1]) + 64'(sqr_q[v][2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Vector lengths: two root pipes, payload held in step
  // ---------------------------------------------------------------------------
  logic [31:0] root [2];
  front_t      fa_q [SQRT_LAT];

  for (genvar v = 0; v < 2; v++) begin : g_len
    lavm_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (ssq_q[v]),
      .root_o (root[v])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_q[0] <= f4_q;
      for (int s = 1; s < SQRT_LAT; s++) fa_q[s] <= fa_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Unit components and the heuristic near plane: seven divider pipes
  // ---------------------------------------------------------------------------
  logic [DVD_W-1:0] quot [2][3];
  logic [DVD_W-1:0] near_quot;
  back_t            b0_d;
  back_t            fb_q [DIV_LAT];

  for (genvar v = 0; v < 2; v++) begin : g_unit
    for (genvar i = 0; i < 3; i++) begin : g_comp
      logic [DVD_W-1:0] dvd;
      // (a * 2^16 + root / 2) / root rounds half away from zero on the magnitude
      assign dvd = {1'b0, fa_q[SQRT_LAT-1].mag[v][i][30:0], 16'b0} + DVD_W'(root[v][31:1]);
      lavm_div u_div (
        .clk_i  (clk_i),
        .en_i   (adv),
        .dvd_i  (dvd),
        .dvs_i  (root[v]),
        .quot_o (quot[v][i])
      );
    end
  end

  lavm_div u_div_near (
    .clk_i  (clk_i),
    .en_i   (adv),
    .dvd_i  ({root[0], 16'b0}),
    .dvs_i  ({1'b0, ratio_q}),
    .quot_o (near_quot)
  );

  always_comb begin
    b0_d.eye      = fa_q[SQRT_LAT-1].eye;
    b0_d.neg      = fa_q[SQRT_LAT-1].neg;
    b0_d.zero     = fa_q[SQRT_LAT-1].zero;
    b0_d.e_d      = fa_q[SQRT_LAT-1].e[0];
    b0_d.far_prod = 63'(root[0]) * 63'(ratio_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fb_q[0] <= b0_d;
      for (int s = 1; s < DIV_LAT; s++) fb_q[s] <= fb_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Q: signed unit vectors and the clip planes in use
  // ---------------------------------------------------------------------------
  function automatic logic [30:0] unscale_sat(input logic [47:0] x, input logic signed [6:0] e);
    logic [50:0] wide;
    logic [50:0] y;
    logic [6:0]  amt;
    wide = {3'b000, x};
    amt  = e[6] ? 7'(-e) : 7'(e);
    y    = e[6] ? (wide << amt) : (wide >> amt);
    return (y > 51'(MAX31)) ? MAX31 : y[30:0];
  endfunction

  mid_t mq_d;
  mid_t mq_q [5];  // Q, V1, V2, V3, V4

  always_comb begin
    logic signed [17:0] mag_s;
    logic signed [17:0] nv [2][3];
    back_t              b;
    b = fb_q[DIV_LAT-1];
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        mag_s    = $signed({1'b0, quot[v][i][16:0]});
        nv[v][i] = b.zero[v] ? 18'sd0 : (b.neg[v][i] ? -mag_s : mag_s);
      end
    end
    mq_d.eye   = b.eye;
    mq_d.t     = nv[0];
    mq_d.u     = nv[1];
    mq_d.vz    = '0;
    mq_d.degen = 1'b0;
    if (near_q != '0 && far_q > near_q) begin
      mq_d.near = near_q;
      mq_d.far  = far_q;
    end else if (ratio_q == '0) begin
      mq_d.near = MAX31;
      mq_d.far  = '0;
    end else begin
      mq_d.near = unscale_sat(near_quot, b.e_d);
      mq_d.far  = unscale_sat(48'(b.far_prod[62:16]), b.e_d);
    end
  end

  // ---------------------------------------------------------------------------
  // V1..V4: dot product of the unit vectors, square, clamp
  // ---------------------------------------------------------------------------
  logic signed [35:0] dp_q [3];
  logic signed [39:0] vzsq_q;
  logic [32:0]        rad_q;
  mid_t               v2_d, v4_d;
  logic [32:0]        rad_d;

  always_comb begin
    logic signed [37:0] s;
    v2_d    = mq_q[1];
    s       = 38'(dp_q[0]) + 38'(dp_q[1]) + 38'(dp_q[2]);
    v2_d.vz = 20'(rnd16(68'(s)));
  end

  always_comb begin
    v4_d = mq_q[3];
    if (vzsq_q > 40'sd4294967296) begin
      v4_d.vz = VZ_ONE;
      rad_d   = '0;
    end else begin
      rad_d   = 33'(40'sd4294967296 - vzsq_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mq_q[0] <= mq_d;
      for (int i = 0; i < 3; i++) dp_q[i] <= mq_q[0].t[i] * mq_q[0].u[i];
      mq_q[1] <= mq_q[0];
      mq_q[2] <= v2_d;
      vzsq_q  <= mq_q[2].vz * mq_q[2].vz;
      mq_q[3] <= mq_q[2];
      mq_q[4] <= v4_d;
      rad_q   <= rad_d;
    end
  end

  // ---------------------------------------------------------------------------
  // vy = sqrt(1 - vz^2), then 1/vy
  // ---------------------------------------------------------------------------
  logic [31:0]      vy;
  logic [DVD_W-1:0] inv_quot;
  mid_t             fc_q [SQRT_LAT];
  mid_t             fd_d;
  mid_t             fd_q [DIV_LAT];

  lavm_sqrt u_sqrt_vy (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (64'(rad_q)),
    .root_o (vy)
  );

  lavm_div u_div_inv (
    .clk_i  (clk_i),
    .en_i   (adv),
    .dvd_i  (DVD_W'(33'h1_0000_0000) + DVD_W'(vy[31:1])),
    .dvs_i  (vy),
    .quot_o (inv_quot)
  );

  // Degenerate camera: up parallel to the sight line
  always_comb begin
    fd_d       = fc_q[SQRT_LAT-1];
    fd_d.degen = (vy == '0);
    if (vy == '0) fd_d.vz = VZ_ONE;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fc_q[0] <= mq_q[4];
      for (int s = 1; s < SQRT_LAT; s++) fc_q[s] <= fc_q[s-1];
      fd_q[0] <= fd_d;
      for (int s = 1; s < DIV_LAT; s++) fd_q[s] <= fd_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // V6 and M1..M8: build the matrix columns
  // ---------------------------------------------------------------------------
  tail_t              tl_q [9];
  tail_t              tl0_d, tl4_d, tl6_d;
  logic signed [37:0] pz_q  [3];
  logic signed [21:0] w_q   [3];
  logic signed [53:0] pw_q  [3];
  logic signed [49:0] xa_q  [3];
  logic signed [49:0] xb_q  [3];
  logic signed [64:0] r3p_q [3][3];
  logic signed [31:0] row3_q [3];

  always_comb begin
    tl0_d.c    = fd_q[DIV_LAT-1];
    tl0_d.col0 = '{default: '0};
    tl0_d.col1 = '{default: '0};
    if (fd_q[DIV_LAT-1].degen || inv_quot > DVD_W'(MAX31)) begin
      tl0_d.vyinv = MAX31;
    end else begin
      tl0_d.vyinv = inv_quot[30:0];
    end
  end

  // M4: column 1 = (u - vz*t) / vy
  always_comb begin
    tl4_d = tl_q[3];
    for (int i = 0; i < 3; i++) tl4_d.col1[i] = sat_rnd(68'(pw_q[i]));
  end

  // M6: column 0 = column 1 x column 2
  always_comb begin
    tl6_d = tl_q[5];
    for (int i = 0; i < 3; i++) tl6_d.col0[i] = sat_rnd(68'(xa_q[i]) - 68'(xb_q[i]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tl_q[0] <= tl0_d;
      // M1
      tl_q[1] <= tl_q[0];
      for (int i = 0; i < 3; i++) pz_q[i] <= tl_q[0].c.vz * tl_q[0].c.t[i];
      // M2
      tl_q[2] <= tl_q[1];
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= 22'(tl_q[1].c.u[i]) - 22'(rnd16(68'(pz_q[i])));
      end
      // M3
      tl_q[3] <= tl_q[2];
      for (int i = 0; i < 3; i++) pw_q[i] <= w_q[i] * $signed({1'b0, tl_q[2].vyinv});
      // M4
      tl_q[4] <= tl4_d;
      // M5
      tl_q[5] <= tl_q[4];
      xa_q[0] <= tl_q[4].col1[1] * tl_q[4].c.t[2];
      xb_q[0] <= tl_q[4].c.t[1] * tl_q[4].col1[2];
      xa_q[1] <= tl_q[4].col1[2] * tl_q[4].c.t[0];
      xb_q[1] <= tl_q[4].c.t[2] * tl_q[4].col1[0];
      xa_q[2] <= tl_q[4].col1[0] * tl_q[4].c.t[1];
      xb_q[2] <= tl_q[4].c.t[0] * tl_q[4].col1[1];
      // M6
      tl_q[6] <= tl6_d;
      // M7: translation row terms, -eye[k] * m[k][c]
      tl_q[7] <= tl_q[6];
      for (int k = 0; k < 3; k++) begin
        r3p_q[0][k] <= (-33'(tl_q[6].c.eye[k])) * tl_q[6].col0[k];
        r3p_q[1][k] <= (-33'(tl_q[6].c.eye[k])) * tl_q[6].col1[k];
        r3p_q[2][k] <= (-33'(tl_q[6].c.eye[k])) * 32'(tl_q[6].c.t[k]);
      end
      // M8
      tl_q[8] <= tl_q[7];
      for (int c = 0; c < 3; c++) begin
        row3_q[c] <= sat_rnd(68'(r3p_q[c][0]) + 68'(r3p_q[c][1]) + 68'(r3p_q[c][2]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row serializer: hold one finished matrix, emit it row by row
  // ---------------------------------------------------------------------------
  logic signed [31:0] mat_d [NUM_ROWS][3];
  logic signed [31:0] mat_q [NUM_ROWS][3];
  logic [30:0]        near_s_q, far_s_q;
  logic               degen_s_q;
  logic               ser_load;

  assign ser_load = adv && vld_q[PIPE_LAT-1];

  // Negate column 0 always, column 1 in line mode
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat_d[r][0] = neg_sat(tl_q[8].col0[r]);
      mat_d[r][1] = line_q ? neg_sat(tl_q[8].col1[r]) : tl_q[8].col1[r];
      mat_d[r][2] = 32'(tl_q[8].c.t[r]);
    end
    mat_d[3][0] = neg_sat(row3_q[0]);
    mat_d[3][1] = line_q ? neg_sat(row3_q[1]) : row3_q[1];
    mat_d[3][2] = row3_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      ser_row_q <= '0;
    end else if (ser_load) begin
      ser_vld_q <= 1'b1;
      ser_row_q <= ROW_X;
    end else if (ser_vld_q && row_o.ready) begin
      if (row_e'(ser_row_q) == ROW_TRANS) begin
        ser_vld_q <= 1'b0;
      end
      ser_row_q <= ser_row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      mat_q     <= mat_d;
      near_s_q  <= tl_q[8].c.near;
      far_s_q   <= tl_q[8].c.far;
      degen_s_q <= tl_q[8].c.degen;
    end
  end

  assign row_o.valid      = ser_vld_q;
  assign row_o.row_index  = ser_row_q;
  assign row_o.col_zero   = mat_q[ser_row_q][0];
  assign row_o.col_one    = mat_q[ser_row_q][1];
  assign row_o.col_two    = mat_q[ser_row_q][2];
  assign row_o.near_out   = near_s_q;
  assign row_o.far_out    = far_s_q;
  assign row_o.degenerate = degen_s_q;
  assign row_o.last_row   = (row_e'(ser_row_q) == ROW_TRANS);

endmodule

FILE: rtl/core/lavm_checker.sv
// Port-level checks of the row sequence of the look-at view matrix unit.
module lavm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        row_valid_i,
  input logic        row_ready_i,
  input logic [1:0]  row_index_i,
  input logic        last_row_i,
  input logic [31:0] col_zero_i
);
  import lavm_pkg::*;

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid_i |-> (last_row_i == (row_e'(row_index_i) == ROW_TRANS)))
    else $error("last_row does not match row_index");

  a_row_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid_i && row_ready_i && !last_row_i) |=>
      (row_valid_i && row_index_i == $past(row_index_i) + 2'd1))
    else $error("matrix rows not emitted back to back in order");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid_i && row_ready_i && last_row_i) |=>
      (!row_valid_i || row_e'(row_index_i) == ROW_X))
    else $error("new matrix does not start at row 0");

  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid_i && !row_ready_i) |=>
      (row_valid_i && $stable(row_index_i) && $stable(col_zero_i)))
    else $error("stalled row word changed");

endmodule

bind look_at_view_matrix_unit lavm_checker u_lavm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .row_valid_i (row_o.valid),
  .row_ready_i (row_o.ready),
  .row_index_i (row_o.row_index),
  .last_row_i  (row_o.last_row),
  .col_zero_i  (row_o.col_zero)
);
